/* rtl/assert_macros.svh */
// assertion macros used by sllt_seq
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge while reset is released
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// checked on every rising edge, reset included
`define ASSERT_CLK(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/sllt_pkg.sv */
// types and constants of the sorted linked list table
`timescale 1ns / 1ps

package sllt_pkg;

	localparam int CAPACITY    = 16;
	localparam int VALUE_WIDTH = 16;
	localparam int OP_W        = 3;
	localparam int SLOT_W      = $clog2(CAPACITY);
	localparam int LINK_W      = $clog2(CAPACITY + 1);
	localparam int CNT_W       = $clog2(CAPACITY + 1);
	localparam int IN_DATA_W   = ((2 * VALUE_WIDTH + 7) / 8) * 8;
	localparam int OUT_DATA_W  = ((SLOT_W + VALUE_WIDTH + 7) / 8) * 8;

	// link code for end of list
	localparam logic [LINK_W-1:0] NONE_LINK = LINK_W'(CAPACITY);

	typedef enum logic [OP_W-1:0] {
		OP_INSERT    = 3'd0,
		OP_DELETE    = 3'd1,
		OP_MODIFY    = 3'd2,
		OP_LIST_ASC  = 3'd3,
		OP_LIST_DESC = 3'd4
	} op_e;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_e;

	typedef struct packed {
		logic                   we;
		logic [SLOT_W-1:0]      addr;
		logic [VALUE_WIDTH-1:0] data;
	} val_wr_t;

	typedef struct packed {
		logic              we;
		logic [SLOT_W-1:0] addr;
		logic [LINK_W-1:0] data;
	} link_wr_t;

	typedef struct packed {
		logic [SLOT_W-1:0] raddr;
		val_wr_t           val_wr;
		link_wr_t          next_wr;
		link_wr_t          prev_wr;
	} mem_req_t;

	typedef struct packed {
		logic [VALUE_WIDTH-1:0] val;
		logic [LINK_W-1:0]      next_link;
		logic [LINK_W-1:0]      prev_link;
	} mem_rsp_t;

	typedef struct packed {
		logic                   valid;
		status_e                status;
		logic [SLOT_W-1:0]      slot;
		logic [VALUE_WIDTH-1:0] item_value;
		logic                   last;
	} result_t;

endpackage

/* rtl/sllt_ram.sv */
// generic single port write, single port read ram with registered read
`timescale 1ns / 1ps

module sllt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/sllt_seq.sv */
// sequencer: list walk, relinking, slot allocation and result generation
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sllt_seq (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [sllt_pkg::OP_W-1:0]        in_op,
	input  logic [sllt_pkg::VALUE_WIDTH-1:0] in_value,
	input  logic [sllt_pkg::VALUE_WIDTH-1:0] in_new_value,
	input  logic                            out_free,
	output sllt_pkg::result_t               res,
	output sllt_pkg::mem_req_t              mem_req,
	input  sllt_pkg::mem_rsp_t              mem_rsp
);

	import sllt_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_CHECK,
		S_WRITE1,
		S_WRITE2,
		S_EMIT
	} state_t;

	state_t                 state_q;
	op_e                    op_q;
	logic [VALUE_WIDTH-1:0] v_q;
	logic [VALUE_WIDTH-1:0] nv_q;
	logic [LINK_W-1:0]      p_q;
	logic [LINK_W-1:0]      pv_q;
	logic [SLOT_W-1:0]      f_q;
	logic [LINK_W-1:0]      head_q;
	logic [LINK_W-1:0]      tail_q;
	logic [CNT_W-1:0]       count_q;
	logic [CAPACITY-1:0]    used_q;
	status_e                res_status_q;
	logic [SLOT_W-1:0]      res_slot_q;
	logic [VALUE_WIDTH-1:0] res_value_q;

	logic [SLOT_W-1:0] free_slot;
	logic              accept;
	logic              is_list;
	logic              is_find;
	logic              val_lt;
	logic              val_eq;
	logic [LINK_W-1:0] step_link;
	logic              list_emit;
	logic              ins_walk;
	logic              fnd_walk;
	logic              lst_walk;

	// lowest slot not in use
	always_comb begin
		free_slot = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_slot = SLOT_W'(i);
			end
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign is_list   = (op_q == OP_LIST_ASC) || (op_q == OP_LIST_DESC);
	assign is_find   = (op_q == OP_DELETE) || (op_q == OP_MODIFY);
	assign val_lt    = $signed(mem_rsp.val) < $signed(v_q);
	assign val_eq    = (mem_rsp.val == v_q);
	assign step_link = (op_q == OP_LIST_DESC) ? mem_rsp.prev_link : mem_rsp.next_link;
	assign list_emit = (state_q == S_CHECK) && is_list && out_free;
	assign ins_walk  = (state_q == S_CHECK) && (op_q == OP_INSERT) && val_lt
		&& (mem_rsp.next_link != NONE_LINK);
	assign fnd_walk  = (state_q == S_CHECK) && is_find && !val_eq
		&& (mem_rsp.next_link != NONE_LINK);
	assign lst_walk  = list_emit && (step_link != NONE_LINK);

	always_comb begin
		mem_req = '0;
		// walk one entry per cycle, lists while output free, via the fetched link
		if (ins_walk || fnd_walk) begin
			mem_req.raddr = mem_rsp.next_link[SLOT_W-1:0];
		end else if (lst_walk) begin
			mem_req.raddr = step_link[SLOT_W-1:0];
		end else begin
			mem_req.raddr = p_q[SLOT_W-1:0];
		end
		case (state_q)
			S_WRITE1: begin
				mem_req.val_wr  = '{we: 1'b1, addr: f_q, data: v_q};
				mem_req.next_wr = '{we: 1'b1, addr: f_q, data: p_q};
				mem_req.prev_wr = '{we: 1'b1, addr: f_q, data: pv_q};
			end
			S_WRITE2: begin
				mem_req.next_wr = '{we: (pv_q != NONE_LINK), addr: pv_q[SLOT_W-1:0],
					data: LINK_W'(f_q)};
				mem_req.prev_wr = '{we: (p_q != NONE_LINK), addr: p_q[SLOT_W-1:0],
					data: LINK_W'(f_q)};
			end
			S_CHECK: begin
				if (op_q == OP_MODIFY && val_eq) begin
					mem_req.val_wr = '{we: 1'b1, addr: p_q[SLOT_W-1:0], data: nv_q};
				end
				if (op_q == OP_DELETE && val_eq) begin
					mem_req.next_wr = '{we: (mem_rsp.prev_link != NONE_LINK),
						addr: mem_rsp.prev_link[SLOT_W-1:0], data: mem_rsp.next_link};
					mem_req.prev_wr = '{we: (mem_rsp.next_link != NONE_LINK),
						addr: mem_rsp.next_link[SLOT_W-1:0], data: mem_rsp.prev_link};
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		res = '{valid: 1'b0, status: res_status_q, slot: res_slot_q,
			item_value: res_value_q, last: 1'b1};
		if (state_q == S_EMIT) begin
			res.valid = out_free;
		end else if (list_emit) begin
			res = '{valid: 1'b1, status: ST_OK, slot: p_q[SLOT_W-1:0],
				item_value: mem_rsp.val, last: (step_link == NONE_LINK)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			op_q         <= OP_INSERT;
			head_q       <= NONE_LINK;
			tail_q       <= NONE_LINK;
			count_q      <= '0;
			used_q       <= '0;
			v_q          <= '0;
			nv_q         <= '0;
			p_q          <= NONE_LINK;
			pv_q         <= NONE_LINK;
			f_q          <= '0;
			res_status_q <= ST_OK;
			res_slot_q   <= '0;
			res_value_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q         <= op_e'(in_op);
						v_q          <= in_value;
						nv_q         <= in_new_value;
						f_q          <= free_slot;
						res_slot_q   <= '0;
						res_value_q  <= '0;
						unique case (op_e'(in_op))
							OP_INSERT: begin
								if (count_q == CNT_W'(CAPACITY)) begin
									res_status_q <= ST_FULL;
									state_q      <= S_EMIT;
								end else if (head_q == NONE_LINK) begin
									p_q     <= NONE_LINK;
									pv_q    <= tail_q;
									state_q <= S_WRITE1;
								end else begin
									p_q     <= head_q;
									state_q <= S_READ;
								end
							end
							OP_DELETE, OP_MODIFY, OP_LIST_ASC: begin
								res_status_q <= ST_EMPTY;
								p_q          <= head_q;
								state_q      <= (count_q == '0) ? S_EMIT : S_READ;
							end
							OP_LIST_DESC: begin
								res_status_q <= ST_EMPTY;
								p_q          <= tail_q;
								state_q      <= (count_q == '0) ? S_EMIT : S_READ;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_READ: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (op_q == OP_INSERT) begin
						if (!val_lt) begin
							pv_q    <= mem_rsp.prev_link;
							state_q <= S_WRITE1;
						end else if (mem_rsp.next_link == NONE_LINK) begin
							p_q     <= NONE_LINK;
							pv_q    <= tail_q;
							state_q <= S_WRITE1;
						end else begin
							p_q <= mem_rsp.next_link;
						end
					end else if (is_find) begin
						if (val_eq) begin
							res_status_q <= ST_OK;
							res_slot_q   <= p_q[SLOT_W-1:0];
							state_q      <= S_EMIT;
							if (op_q == OP_MODIFY) begin
								res_value_q <= nv_q;
							end else begin
								res_value_q <= mem_rsp.val;
								used_q[p_q[SLOT_W-1:0]] <= 1'b0;
								count_q <= count_q - CNT_W'(1);
								if (mem_rsp.prev_link == NONE_LINK) begin
									head_q <= mem_rsp.next_link;
								end
								if (mem_rsp.next_link == NONE_LINK) begin
									tail_q <= mem_rsp.prev_link;
								end
							end
						end else if (mem_rsp.next_link == NONE_LINK) begin
							res_status_q <= ST_NOT_FOUND;
							state_q      <= S_EMIT;
						end else begin
							p_q <= mem_rsp.next_link;
						end
					end else begin
						// list op: stalled output means re-read the current entry
						if (!out_free) begin
							state_q <= S_READ;
						end else if (step_link == NONE_LINK) begin
							state_q <= S_IDLE;
						end else begin
							p_q <= step_link;
						end
					end
				end
				S_WRITE1: begin
					used_q[f_q] <= 1'b1;
					count_q     <= count_q + CNT_W'(1);
					if (pv_q == NONE_LINK) begin
						head_q <= LINK_W'(f_q);
					end
					if (p_q == NONE_LINK) begin
						tail_q <= LINK_W'(f_q);
					end
					state_q <= S_WRITE2;
				end
				S_WRITE2: begin
					res_status_q <= ST_OK;
					res_slot_q   <= f_q;
					res_value_q  <= v_q;
					state_q      <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`ASSERT_CLK(a_count_bound, clk, !arst_n || count_q <= CNT_W'(CAPACITY), "entry count over capacity")
	`ASSERT_RST(a_count_used, clk, arst_n, $countones(used_q) == int'(count_q), "count != used")
	`ASSERT_RST(a_head_empty, clk, arst_n, (count_q == '0) == (head_q == NONE_LINK), "head/count")
	`ASSERT_RST(a_res_free, clk, arst_n, res.valid |-> out_free, "result with output busy")

endmodule

/* rtl/sorted_linked_list_table_unit.sv */
// Sorted doubly linked list table: link rams, sequencer and output register.
// An insert walks to its place, writes the new entry and relinks its neighbours; delete and
// modify walk to the match. A list op gives one result per cycle while the output is free.
// Only one operation is in flight at a time, set by the serial walk of the link rams at one read per cycle.
// Reset: entry count, used bits, head, tail and output valid clear at once; the rams need
// no clearing pass, entries are only read once linked.
`timescale 1ns / 1ps

module sorted_linked_list_table_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [sllt_pkg::IN_DATA_W-1:0]  s_tdata,   // value, new_value
	input  logic [sllt_pkg::OP_W-1:0]       s_tuser,   // op
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [sllt_pkg::OUT_DATA_W-1:0] m_tdata,   // slot, item_value, zero pad
	output logic [1:0]                     m_tuser,   // status
	output logic                           m_tlast
);

	import sllt_pkg::*;

	mem_req_t mem_req;
	mem_rsp_t mem_rsp;
	result_t  res;
	logic     out_free;

	logic                   out_valid_q;
	status_e                out_status_q;
	logic [SLOT_W-1:0]      out_slot_q;
	logic [VALUE_WIDTH-1:0] out_value_q;
	logic                   out_last_q;

	sllt_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(CAPACITY)) u_val_ram (
		.clk   (clk),
		.we    (mem_req.val_wr.we),
		.waddr (mem_req.val_wr.addr),
		.wdata (mem_req.val_wr.data),
		.raddr (mem_req.raddr),
		.rdata (mem_rsp.val)
	);

	sllt_ram #(.WIDTH(LINK_W), .DEPTH(CAPACITY)) u_next_ram (
		.clk   (clk),
		.we    (mem_req.next_wr.we),
		.waddr (mem_req.next_wr.addr),
		.wdata (mem_req.next_wr.data),
		.raddr (mem_req.raddr),
		.rdata (mem_rsp.next_link)
	);

	sllt_ram #(.WIDTH(LINK_W), .DEPTH(CAPACITY)) u_prev_ram (
		.clk   (clk),
		.we    (mem_req.prev_wr.we),
		.waddr (mem_req.prev_wr.addr),
		.wdata (mem_req.prev_wr.data),
		.raddr (mem_req.raddr),
		.rdata (mem_rsp.prev_link)
	);

	sllt_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.in_op        (s_tuser),
		.in_value     (s_tdata[VALUE_WIDTH-1:0]),
		.in_new_value (s_tdata[2*VALUE_WIDTH-1:VALUE_WIDTH]),
		.out_free     (out_free),
		.res          (res),
		.mem_req      (mem_req),
		.mem_rsp      (mem_rsp)
	);

	assign out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			out_status_q <= ST_OK;
			out_slot_q   <= '0;
			out_value_q  <= '0;
			out_last_q   <= 1'b0;
		end else begin
			if (res.valid) begin
				out_valid_q  <= 1'b1;
				out_status_q <= res.status;
				out_slot_q   <= res.slot;
				out_value_q  <= res.item_value;
				out_last_q   <= res.last;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_DATA_W'({out_value_q, out_slot_q});
	assign m_tuser  = out_status_q;
	assign m_tlast  = out_last_q;

endmodule
